>>> rtl/fpbc_pkg.sv
// Shared widths, types and codes for the frustum point/box cull pipeline.
// No dependencies; used by every module of the block.
`default_nettype none

package fpbc_pkg;

    localparam int Q_W         = 32;        // signed Q16.16 word
    localparam int FRAC_W      = 16;
    localparam int PROD_W      = 2 * Q_W;   // exact Q32.32 product
    localparam int DOT_W       = PROD_W + 2; // sum of four products
    localparam int PLANE_W     = DOT_W + 1; // sum or difference of two dots
    localparam int NUM_COLS    = 4;
    localparam int NUM_AXES    = 3;
    localparam int NUM_SIDES   = 2;         // box minimum and maximum
    localparam int NUM_CORNERS = 8;
    localparam int NUM_REGS    = 8;
    localparam int REG_W       = 64;
    localparam int REG_IDX_W   = 3;
    localparam int IN_DATA_W   = 2 * NUM_AXES * Q_W;
    localparam int OUT_DATA_W  = 8;

    typedef enum logic
    {
        ACT_POINT = 1'b0,
        ACT_BOX   = 1'b1
    } action_t;

    typedef struct packed
    {
        logic    valid;
        action_t action;
    } stage_ctl_t;

    // one matrix column: entries of rows 1..4
    typedef struct packed
    {
        logic [Q_W-1:0] e3;
        logic [Q_W-1:0] e2;
        logic [Q_W-1:0] e1;
        logic [Q_W-1:0] e0;
    } column_t;

    typedef column_t [NUM_COLS-1:0] matrix_t;

    typedef logic [NUM_AXES-1:0][Q_W-1:0] axis_vec_t;

    typedef struct packed
    {
        axis_vec_t hi;
        axis_vec_t lo;
    } box_t;

    // products indexed [column][axis][side], side 0 = lo, 1 = hi
    typedef logic [NUM_COLS-1:0][NUM_AXES-1:0][NUM_SIDES-1:0][PROD_W-1:0] prod_set_t;

    // column dot products indexed [corner][column]
    typedef logic [NUM_CORNERS-1:0][NUM_COLS-1:0][DOT_W-1:0] dot_set_t;

endpackage

`default_nettype wire

>>> rtl/fpbc_mult.sv
// Stage 1: matrix entry by coordinate products for both box sides.
// Depends on fpbc_pkg.
`default_nettype none

module fpbc_mult
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fpbc_pkg::stage_ctl_t in_ctl,
    output logic                      in_ready,
    input  wire fpbc_pkg::box_t       box,
    input  wire fpbc_pkg::matrix_t    matrix,
    output fpbc_pkg::stage_ctl_t      out_ctl,
    input  wire logic                 out_ready,
    output fpbc_pkg::prod_set_t       prod
);

    fpbc_pkg::stage_ctl_t ctl_reg;
    fpbc_pkg::prod_set_t  prod_reg;
    fpbc_pkg::prod_set_t  prod_next;
    logic                 advance;

    assign advance  = !ctl_reg.valid || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        logic signed [fpbc_pkg::Q_W-1:0] coef;
        logic signed [fpbc_pkg::Q_W-1:0] coord;
        prod_next = '0;
        for (int c = 0; c < fpbc_pkg::NUM_COLS; c++)
        begin
            for (int a = 0; a < fpbc_pkg::NUM_AXES; a++)
            begin
                case (a)
                    0:       coef = $signed(matrix[c].e0);
                    1:       coef = $signed(matrix[c].e1);
                    default: coef = $signed(matrix[c].e2);
                endcase
                for (int s = 0; s < fpbc_pkg::NUM_SIDES; s++)
                begin
                    coord = (s != 0) ? $signed(box.hi[a]) : $signed(box.lo[a]);
                    prod_next[c][a][s] = fpbc_pkg::PROD_W'(coef) *
                                         fpbc_pkg::PROD_W'(coord);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (advance)
            ctl_reg <= in_ctl;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_ctl.valid)
            prod_reg <= prod_next;
    end

    assign out_ctl = ctl_reg;
    assign prod    = prod_reg;

endmodule

`default_nettype wire

>>> rtl/fpbc_sum.sv
// Stage 2: column dot products for each of the eight corners.
// Depends on fpbc_pkg.
`default_nettype none

module fpbc_sum
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fpbc_pkg::stage_ctl_t in_ctl,
    output logic                      in_ready,
    input  wire fpbc_pkg::prod_set_t  prod,
    input  wire fpbc_pkg::matrix_t    matrix,
    output fpbc_pkg::stage_ctl_t      out_ctl,
    input  wire logic                 out_ready,
    output fpbc_pkg::dot_set_t        dots
);

    fpbc_pkg::stage_ctl_t ctl_reg;
    fpbc_pkg::dot_set_t   dots_reg;
    fpbc_pkg::dot_set_t   dots_next;
    logic                 advance;

    assign advance  = !ctl_reg.valid || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        logic [2:0]                                              kb;
        logic signed [fpbc_pkg::Q_W+fpbc_pkg::FRAC_W-1:0]       w_term;
        dots_next = '0;
        for (int k = 0; k < fpbc_pkg::NUM_CORNERS; k++)
        begin
            kb = 3'(k);   // bit 0 picks x side, bit 1 y, bit 2 z
            for (int c = 0; c < fpbc_pkg::NUM_COLS; c++)
            begin
                w_term = $signed({matrix[c].e3, {fpbc_pkg::FRAC_W{1'b0}}});
                dots_next[k][c] =
                    fpbc_pkg::DOT_W'($signed(prod[c][0][kb[0]])) +
                    fpbc_pkg::DOT_W'($signed(prod[c][1][kb[1]])) +
                    fpbc_pkg::DOT_W'($signed(prod[c][2][kb[2]])) +
                    fpbc_pkg::DOT_W'(w_term);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (advance)
            ctl_reg <= in_ctl;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_ctl.valid)
            dots_reg <= dots_next;
    end

    assign out_ctl = ctl_reg;
    assign dots    = dots_reg;

endmodule

`default_nettype wire

>>> rtl/fpbc_plane.sv
// Stage 3: six plane signs per corner, corner merge, output register.
// Depends on fpbc_pkg.
`default_nettype none

module fpbc_plane
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fpbc_pkg::stage_ctl_t in_ctl,
    output logic                      in_ready,
    input  wire fpbc_pkg::dot_set_t   dots,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      in_frustum
);

    logic                               valid_reg;
    logic                               inside_reg;
    logic                               inside_next;
    logic [fpbc_pkg::NUM_CORNERS-1:0]   corner_in;
    logic                               advance;

    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        logic signed [fpbc_pkg::PLANE_W-1:0] d0, d1, d2, d3;
        logic [5:0]                          neg;
        corner_in = '0;
        for (int k = 0; k < fpbc_pkg::NUM_CORNERS; k++)
        begin
            d0 = fpbc_pkg::PLANE_W'($signed(dots[k][0]));
            d1 = fpbc_pkg::PLANE_W'($signed(dots[k][1]));
            d2 = fpbc_pkg::PLANE_W'($signed(dots[k][2]));
            d3 = fpbc_pkg::PLANE_W'($signed(dots[k][3]));
            // left, right, top, bottom, near, far
            neg[0] = (d3 + d0) < 0;
            neg[1] = (d3 - d0) < 0;
            neg[2] = (d3 - d1) < 0;
            neg[3] = (d3 + d1) < 0;
            neg[4] = d2 < 0;
            neg[5] = (d3 - d2) < 0;
            corner_in[k] = ~|neg;
        end
        // a point is the all-minimum corner
        if (in_ctl.action == fpbc_pkg::ACT_BOX)
            inside_next = |corner_in;
        else
            inside_next = corner_in[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_ctl.valid)
            inside_reg <= inside_next;
    end

    assign out_valid  = valid_reg;
    assign in_frustum = inside_reg;

endmodule

`default_nettype wire

>>> rtl/frustum_point_box_cull.sv
// Frustum cull of a point or axis-aligned box against six planes from a 4x4 matrix.
// Throughput: one transaction per cycle unless m_tready stalls, set by the three-stage
// multiply/sum/plane pipe, whose stage registers each transaction passes in turn.
// Reset: rst_n asynchronous active low; clears pipeline valids and matrix registers.
// Depends on fpbc_pkg, fpbc_mult, fpbc_sum, fpbc_plane.
`default_nettype none

module frustum_point_box_cull
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration write port
    input  wire logic                               cfg_we,
    input  wire logic [fpbc_pkg::REG_IDX_W-1:0]     cfg_index,
    input  wire logic [fpbc_pkg::REG_W-1:0]         cfg_data,
    // input stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata from bit 0: x_lo, y_lo, z_lo, x_hi, y_hi, z_hi (32 bits each)
    input  wire logic [fpbc_pkg::IN_DATA_W-1:0]     s_tdata,
    // s_tuser bit 0: action (0 point, 1 box)
    input  wire logic [0:0]                         s_tuser,
    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata from bit 0: inside_res, then zero padding
    output logic [fpbc_pkg::OUT_DATA_W-1:0]         m_tdata
);

    // Matrix registers: two Q16.16 entries each, first-named entry in the low word.
    // Register 2c holds rows 1 and 2 of column c, register 2c+1 rows 3 and 4.
    logic [fpbc_pkg::REG_W-1:0] cfg_reg [fpbc_pkg::NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fpbc_pkg::NUM_REGS; i++)
                cfg_reg[i] <= '0;
        end
        else if (cfg_we)
            cfg_reg[cfg_index] <= cfg_data;
    end

    fpbc_pkg::matrix_t matrix;

    always_comb
    begin
        for (int c = 0; c < fpbc_pkg::NUM_COLS; c++)
        begin
            matrix[c].e0 = cfg_reg[2*c][fpbc_pkg::Q_W-1:0];
            matrix[c].e1 = cfg_reg[2*c][fpbc_pkg::REG_W-1:fpbc_pkg::Q_W];
            matrix[c].e2 = cfg_reg[2*c+1][fpbc_pkg::Q_W-1:0];
            matrix[c].e3 = cfg_reg[2*c+1][fpbc_pkg::REG_W-1:fpbc_pkg::Q_W];
        end
    end

    // unpack the incoming transaction
    fpbc_pkg::stage_ctl_t in_ctl;
    fpbc_pkg::box_t       box;

    always_comb
    begin
        in_ctl.valid  = s_tvalid;
        in_ctl.action = fpbc_pkg::action_t'(s_tuser[0]);
        for (int a = 0; a < fpbc_pkg::NUM_AXES; a++)
        begin
            box.lo[a] = s_tdata[a*fpbc_pkg::Q_W +: fpbc_pkg::Q_W];
            box.hi[a] = s_tdata[(a+fpbc_pkg::NUM_AXES)*fpbc_pkg::Q_W +: fpbc_pkg::Q_W];
        end
    end

    // Each stage holds while the one after it is full and stalled; the ready
    // chain runs back from m_tready so a stall never drops or repeats a transaction.
    fpbc_pkg::stage_ctl_t mult_ctl;
    fpbc_pkg::stage_ctl_t sum_ctl;
    fpbc_pkg::prod_set_t  prod;
    fpbc_pkg::dot_set_t   dots;
    logic                 sum_ready;
    logic                 plane_ready;
    logic                 in_frustum;

    // stage 1: 24 products, every entry of rows 1..3 against both box sides
    fpbc_mult u_mult
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (in_ctl),
        .in_ready  (s_tready),
        .box       (box),
        .matrix    (matrix),
        .out_ctl   (mult_ctl),
        .out_ready (sum_ready),
        .prod      (prod)
    );

    // stage 2: four column dots per corner, exact at 66 bits
    fpbc_sum u_sum
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (mult_ctl),
        .in_ready  (sum_ready),
        .prod      (prod),
        .matrix    (matrix),
        .out_ctl   (sum_ctl),
        .out_ready (plane_ready),
        .dots      (dots)
    );

    // stage 3: plane signs, corner OR for boxes, output register
    fpbc_plane u_plane
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ctl     (sum_ctl),
        .in_ready   (plane_ready),
        .dots       (dots),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .in_frustum (in_frustum)
    );

    assign m_tdata = {{(fpbc_pkg::OUT_DATA_W-1){1'b0}}, in_frustum};

endmodule

`default_nettype wire

>>> rtl/fpbc_checker.sv
// Port-level checks for frustum_point_box_cull, attached by bind.
// Depends on fpbc_pkg and the top level's ports.
`default_nettype none

module fpbc_checker
(
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_tvalid,
    input wire logic                               s_tready,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [fpbc_pkg::OUT_DATA_W-1:0]    m_tdata
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

    // a result only appears after an accepted input transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 3))
    else $error("result without matching input");

    // with the output open, an accepted transaction reaches the output and is not lost
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(s_tvalid && s_tready, 3) && $past(m_tready, 1) && $past(m_tready, 2) &&
        $past(rst_n, 1) && $past(rst_n, 2) |-> m_tvalid)
    else $error("transaction lost in pipeline");

    // padding above the result bit is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[fpbc_pkg::OUT_DATA_W-1:1] == '0)
    else $error("nonzero padding in m_tdata");

endmodule

bind frustum_point_box_cull fpbc_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking bench for frustum_point_box_cull: stream stimulus, frustum predictor
// and scoreboard. Depends on rtl/fpbc_pkg.sv and the frustum_point_box_cull RTL.
`timescale 1ns / 100ps

module tb_top;
    import fpbc_pkg::*;

    // Q16.16 constants used by the stimulus
    localparam logic [31:0] Q_ZERO    = 32'h0000_0000;
    localparam logic [31:0] Q_ONE     = 32'h0001_0000;
    localparam logic [31:0] Q_HALF    = 32'h0000_8000;
    localparam logic [31:0] Q_TWO     = 32'h0002_0000;
    localparam logic [31:0] Q_THREE   = 32'h0003_0000;
    localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
    localparam logic [31:0] Q_NEG_3   = 32'hFFFD_0000;
    localparam logic [31:0] Q_NEG_ULP = 32'hFFFF_FFFF;
    localparam logic [31:0] Q_MIN     = 32'h8000_0000;
    localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;

    localparam int NUM_DIR         = 23;
    localparam int RAND_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 92;
    localparam int SETTLE_CYCLES   = 8;     // pipe is 3 deep, a little margin
    localparam int HOLD_AT         = 200;   // input count that triggers the long back-pressure
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int MAX_REPORTS     = 10;

    // register map of the configuration port
    typedef enum logic [REG_IDX_W-1:0]
    {
        REG_COL1_ROW12 = 3'd0,
        REG_COL1_ROW34 = 3'd1,
        REG_COL2_ROW12 = 3'd2,
        REG_COL2_ROW34 = 3'd3,
        REG_COL3_ROW12 = 3'd4,
        REG_COL3_ROW34 = 3'd5,
        REG_COL4_ROW12 = 3'd6,
        REG_COL4_ROW34 = 3'd7
    } cfg_reg_t;

    // matrix settings the run goes through
    typedef enum int
    {
        MAT_ZERO,       // reset contents
        MAT_IDENT,
        MAT_MIN,        // every entry most negative
        MAT_MAX,        // every entry most positive
        MAT_ONES,       // every entry -1 ulp
        MAT_NEAR_ID,    // perturbed identity, gives a healthy mix of hits and misses
        MAT_RANDOM
    } matrix_kind_t;

    typedef struct
    {
        matrix_kind_t kind;
        action_t      act;
        logic [31:0]  xl, yl, zl, xh, yh, zh;
        bit           typed;    // expected result written in the row
        bit           want;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [REG_IDX_W-1:0]  cfg_index;
    logic [REG_W-1:0]      cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    // s_tdata from bit 0: x_lo, y_lo, z_lo, x_hi, y_hi, z_hi
    logic [IN_DATA_W-1:0]  s_tdata;
    // s_tuser bit 0: action
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // m_tdata from bit 0: inside_res, zero padding
    logic [OUT_DATA_W-1:0] m_tdata;

    // shadow of the matrix registers and the results still owed by the block
    logic [REG_W-1:0] mat_regs [NUM_REGS];
    bit               pending_inside [$];

    int  fail_count  = 0;
    int  in_count    = 0;
    int  idle_cycles = 0;
    int  tx_calm     = 0;

    // Directed rows. The zero matrix (reset) accepts everything; with the identity the
    // frustum is -1 <= x,y <= 1, 0 <= z <= 1 with closed faces, so those rows read at a
    // glance. Boxes with mixed corners and the extreme matrix go through the predictor.
    dir_row_t dir_rows [NUM_DIR] = '{
        '{MAT_ZERO,  ACT_POINT, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1, 1'b1},
        '{MAT_ZERO,  ACT_POINT, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b1, 1'b1},
        '{MAT_ZERO,  ACT_BOX,   Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b1, 1'b1},
        '{MAT_ZERO,  ACT_BOX,   Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 1'b1, 1'b1},
        '{MAT_IDENT, ACT_POINT, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1, 1'b1},
        '{MAT_IDENT, ACT_POINT, Q_ZERO, Q_ZERO, Q_HALF, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1, 1'b1},
        // on the right, top and far faces at once
        '{MAT_IDENT, ACT_POINT, Q_ONE, Q_ONE, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1, 1'b1},
        '{MAT_IDENT, ACT_POINT, Q_ONE + 32'd1, Q_ZERO, Q_HALF, Q_ZERO, Q_ZERO, Q_ZERO,
          1'b1, 1'b0},
        '{MAT_IDENT, ACT_POINT, Q_ZERO, Q_ZERO, Q_NEG_ULP, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1, 1'b0},
        '{MAT_IDENT, ACT_POINT, Q_NEG_ONE, Q_NEG_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
          1'b1, 1'b1},
        '{MAT_IDENT, ACT_POINT, Q_MIN, Q_MIN, Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1, 1'b0},
        '{MAT_IDENT, ACT_POINT, Q_MAX, Q_MAX, Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1, 1'b0},
        // point with junk in the maximum fields, which must be ignored
        '{MAT_IDENT, ACT_POINT, Q_ZERO, Q_ZERO, Q_HALF, Q_MIN, Q_MIN, Q_MIN, 1'b1, 1'b1},
        '{MAT_IDENT, ACT_BOX,   Q_TWO, Q_TWO, Q_TWO, Q_THREE, Q_THREE, Q_THREE, 1'b1, 1'b0},
        '{MAT_IDENT, ACT_BOX,   Q_NEG_3, Q_NEG_3, Q_NEG_3, Q_THREE, Q_THREE, Q_THREE,
          1'b0, 1'b0},
        // minimum above maximum: corners taken as given
        '{MAT_IDENT, ACT_BOX,   Q_THREE, Q_THREE, Q_THREE, Q_ZERO, Q_ZERO, Q_HALF, 1'b0, 1'b0},
        '{MAT_IDENT, ACT_BOX,   Q_HALF, Q_HALF, Q_HALF, Q_THREE, Q_THREE, Q_THREE, 1'b0, 1'b0},
        '{MAT_IDENT, ACT_BOX,   Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b0, 1'b0},
        '{MAT_MIN,   ACT_POINT, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0, 1'b0},
        '{MAT_MIN,   ACT_POINT, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b0, 1'b0},
        '{MAT_MIN,   ACT_POINT, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 1'b0, 1'b0},
        '{MAT_MIN,   ACT_BOX,   Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b0, 1'b0},
        '{MAT_MIN,   ACT_BOX,   Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 1'b0, 1'b0}
    };

    // settings of the random part; perturbed identity between the extremes
    matrix_kind_t rand_kinds [RAND_PHASES] = '{
        MAT_NEAR_ID, MAT_RANDOM, MAT_NEAR_ID, MAT_MAX, MAT_NEAR_ID, MAT_ONES
    };

    frustum_point_box_cull DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // matrix entry at row r, column c (both 0..3) from the shadow registers
    function automatic logic signed [31:0] mat_entry(int r, int c);
        logic [REG_W-1:0] w;
        w = mat_regs[c * 2 + r / 2];
        return (r % 2) ? w[63:32] : w[31:0];
    endfunction

    // Plane values are exact Q32.32 at 80 bits, far more than the 67 needed,
    // so the sign bit is the whole verdict.
    function automatic bit point_in_frustum(logic signed [31:0] px, logic signed [31:0] py,
                                            logic signed [31:0] pz);
        logic signed [79:0] vx, vy, vz;
        logic signed [79:0] e0, e1, e2, e3;
        logic signed [79:0] dot [4];
        logic signed [79:0] pl [6];
        bit                 ok;
        vx = px;
        vy = py;
        vz = pz;
        for (int c = 0; c < 4; c++)
        begin
            e0 = mat_entry(0, c);
            e1 = mat_entry(1, c);
            e2 = mat_entry(2, c);
            e3 = mat_entry(3, c);
            dot[c] = e0 * vx + e1 * vy + e2 * vz + e3 * 80'sd65536;
        end
        pl[0] = dot[3] + dot[0];    // left
        pl[1] = dot[3] - dot[0];    // right
        pl[2] = dot[3] - dot[1];    // top
        pl[3] = dot[3] + dot[1];    // bottom
        pl[4] = dot[2];             // near
        pl[5] = dot[3] - dot[2];    // far
        ok = 1'b1;
        for (int k = 0; k < 6; k++)
            if (pl[k][79])
                ok = 1'b0;
        return ok;
    endfunction

    // point: one test on the minimum fields; box: any of the eight corners
    function automatic bit frustum_inside(action_t act, logic [IN_DATA_W-1:0] d);
        logic signed [31:0] lo [3];
        logic signed [31:0] hi [3];
        logic signed [31:0] cx, cy, cz;
        bit                 hit;
        for (int k = 0; k < 3; k++)
        begin
            lo[k] = d[32 * k +: 32];
            hi[k] = d[32 * (k + 3) +: 32];
        end
        if (act == ACT_POINT)
            return point_in_frustum(lo[0], lo[1], lo[2]);
        hit = 1'b0;
        for (int k = 0; k < 8; k++)
        begin
            cx = (k & 1) ? hi[0] : lo[0];
            cy = (k & 2) ? hi[1] : lo[1];
            cz = (k & 4) ? hi[2] : lo[2];
            hit = hit | point_in_frustum(cx, cy, cz);
        end
        return hit;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    // mostly values near the unit frustum, some full range, extremes and face hits
    function automatic logic [31:0] rand_coord();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return $urandom_range(3 * 65536) - 32'd98304;
        if (sel < 78)
            return $urandom;
        if (sel < 90)
        begin
            case ($urandom_range(3))
                0:       return Q_MIN;
                1:       return Q_MAX;
                2:       return Q_ZERO;
                default: return Q_NEG_ULP;
            endcase
        end
        return ($urandom_range(1) ? Q_ONE : Q_NEG_ONE) + $urandom_range(2) - 32'd1;
    endfunction

    // input gaps: mostly none or short, a few long, and calm stretches with none
    function automatic int pick_tx_gap();
        int unsigned sel;
        if (tx_calm > 0)
        begin
            tx_calm--;
            return 0;
        end
        if ($urandom_range(49) == 0)
            tx_calm = $urandom_range(20, 60);
        sel = $urandom_range(99);
        if (sel < 50)
            return 0;
        if (sel < 85)
            return $urandom_range(1, 3);
        if (sel < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s", $time, msg);
    endfunction

    // Offer one transaction, wait for the handshake and record what it must produce.
    // tvalid is left high when the next transaction follows without a gap.
    task automatic send_item(action_t act, logic [IN_DATA_W-1:0] d, bit typed, bit want);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= act;
        do
            @(posedge clk);
        while (!s_tready);
        pending_inside.push_back(typed ? want : frustum_inside(act, d));
        in_count++;
        gap = pick_tx_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering and let the pipe empty before touching the registers
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_inside.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all eight registers for the given setting, one per cycle
    task automatic load_matrix(matrix_kind_t kind);
        logic [31:0]      e [4][4];
        logic [REG_W-1:0] val;
        int               c, h;
        for (int r = 0; r < 4; r++)
            for (int cc = 0; cc < 4; cc++)
            begin
                case (kind)
                    MAT_IDENT:   e[r][cc] = (r == cc) ? Q_ONE : Q_ZERO;
                    MAT_MIN:     e[r][cc] = Q_MIN;
                    MAT_MAX:     e[r][cc] = Q_MAX;
                    MAT_ONES:    e[r][cc] = Q_NEG_ULP;
                    MAT_RANDOM:  e[r][cc] = $urandom;
                    MAT_NEAR_ID: e[r][cc] = (r == cc) ? Q_HALF + $urandom_range(65536)
                                                      : $urandom_range(16384) - 32'd8192;
                    default:     e[r][cc] = Q_ZERO;
                endcase
            end
        for (int i = 0; i < NUM_REGS; i++)
        begin
            c   = i / 2;
            h   = i % 2;
            val = {e[2 * h + 1][c], e[2 * h][c]};
            cfg_we      <= 1'b1;
            cfg_index   <= cfg_reg_t'(i);
            cfg_data    <= val;
            mat_regs[i] = val;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Scoreboard: every result transaction against the oldest expectation
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        bit want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_inside.size() == 0)
                note_failure($sformatf("result with nothing pending: m_tdata %h", m_tdata));
            else
            begin
                want = pending_inside.pop_front();
                if (m_tdata !== OUT_DATA_W'(want))
                    note_failure($sformatf("inside mismatch: expected m_tdata %h, got %h",
                                           OUT_DATA_W'(want), m_tdata));
            end
        end
    end

    // Watchdog: cycles with no transaction on any port
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_inside.size());
            $display("[frustum_point_box_cull] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver: random ready runs and stalls, plus one long hold-off mid-run so the
    // pipe fills and s_tready drops while the sender keeps offering.
    initial
    begin
        bit hold_done;
        int sel;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!hold_done && in_count >= HOLD_AT)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                sel = $urandom_range(99);
                m_tready <= 1'b1;
                if (sel < 10)
                    repeat ($urandom_range(100, 200)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                m_tready <= 1'b0;
                if (sel >= 93)
                    repeat ($urandom_range(20, 50)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 3)) @(posedge clk);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        matrix_kind_t         cur_kind;
        action_t              act;
        logic [IN_DATA_W-1:0] word;
        logic [31:0]          a, b, t;
        dir_row_t             row;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        for (int i = 0; i < NUM_REGS; i++)
            mat_regs[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; the first rows run on the reset matrix
        cur_kind = MAT_ZERO;
        for (int i = 0; i < NUM_DIR; i++)
        begin
            row = dir_rows[i];
            if (row.kind != cur_kind)
            begin
                drain();
                load_matrix(row.kind);
                cur_kind = row.kind;
            end
            send_item(row.act, {row.zh, row.yh, row.xh, row.zl, row.yl, row.xl},
                      row.typed, row.want);
        end

        // random part: a fresh matrix per phase, then a stream of points and boxes
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain();
            load_matrix(rand_kinds[ph]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                act = action_t'($urandom_range(1));
                for (int k = 0; k < 3; k++)
                begin
                    a = rand_coord();
                    b = rand_coord();
                    // most boxes well formed, the rest as drawn
                    if ($urandom_range(3) != 0 && $signed(a) > $signed(b))
                    begin
                        t = a;
                        a = b;
                        b = t;
                    end
                    word[32 * k +: 32]       = a;
                    word[32 * (k + 3) +: 32] = b;
                end
                send_item(act, word, 1'b0, 1'b0);
            end
        end

        drain();
        if (fail_count == 0)
            $display("[frustum_point_box_cull] OK");
        else
            $display("[frustum_point_box_cull] ERROR");
        $finish;
    end

endmodule
